// File: src/utf16be_to_utf8_encoder_macros.svh
// Assertion macros shared by the UTF-16 to UTF-8 encoder RTL.
`ifndef UTF16BE_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16BE_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U16U8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/u16u8_pkg.sv
// Types and constants for the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

    localparam int UNIT_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;

    // Upper six bits of a code unit that mark a surrogate
    localparam logic [5:0] SURR_HI_TAG = 6'b110110;
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;

    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] LEAD4_MARK = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [3:0] SURR_NIBBLE = 4'hD;

    // Element 0 is the first byte on the wire
    typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_buf_t;
    typedef logic [2:0][BYTE_W-1:0]           unit_bytes_t;

endpackage

// File: src/utf16be_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder.
`include "utf16be_to_utf8_encoder_macros.svh"

// UTF-16 code units in on s_*, UTF-8 bytes out on m_*, one byte per transfer.
// A unit is encoded in the cycle it is accepted into a six-byte holding buffer,
// which feeds the output register one byte per cycle unless the output stalls. A
// BMP unit yields one to three bytes, a surrogate pair four (charged to the
// low unit); a held high surrogate yields none and adds three more bytes when
// it is flushed. The next unit is accepted in the same cycle the last buffered
// byte moves to the output register, so there is no gap between units; the
// first byte of a unit goes through the holding buffer and then the output
// register before it appears on m_tdata.
// m_tlast marks the last byte of each input unit, m_tuser marks the NUL byte
// that ends a string. A zero unit flushes any held surrogate first.
module utf16be_to_utf8_encoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [u16u8_pkg::UNIT_W-1:0]         s_tdata,   // [15:0] code_unit
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [u16u8_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] out_byte
    output logic                                 m_tlast,   // run_last
    output logic                                 m_tuser    // [0] string_end
);
    import u16u8_pkg::*;

    logic [9:0]       held_reg;
    logic [9:0]       held_next;
    logic             held_valid_reg;
    logic             held_valid_next;
    byte_buf_t        buf_reg;
    byte_buf_t        buf_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             end_reg;
    logic             end_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;
    logic             m_tuser_reg;

    logic             s_xfer;
    logic             out_free;
    logic             out_load;
    logic             is_hi;
    logic             is_lo;
    logic             pair;
    logic             flush;
    logic [10:0]      plane_bits;
    logic [15:0]      held_unit;
    unit_bytes_t      cur_bytes;
    logic [CNT_W-1:0] cur_cnt;
    byte_buf_t        enc_bytes;
    logic [CNT_W-1:0] enc_cnt;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free && (cnt_reg != '0);
    // Take a new unit when the buffer is empty or drains this cycle
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_load);
    assign s_xfer   = s_tvalid && s_tready;

    assign is_hi = (s_tdata[15:10] == SURR_HI_TAG);
    assign is_lo = (s_tdata[15:10] == SURR_LO_TAG);
    assign pair  = held_valid_reg && is_lo;
    assign flush = held_valid_reg && !is_lo;

    // Bits 20..10 of the supplementary code point
    assign plane_bits = {1'b0, held_reg} + 11'h040;
    assign held_unit  = {SURR_HI_TAG, held_reg};

    // Encoding of the current unit on its own
    always_comb
    begin
        cur_bytes = '0;
        cur_cnt   = '0;
        if (s_tdata == '0)
        begin
            cur_cnt = CNT_W'(1);
        end
        else if (s_tdata[15:7] == '0)
        begin
            cur_bytes[0] = s_tdata[7:0];
            cur_cnt      = CNT_W'(1);
        end
        else if (s_tdata[15:11] == '0)
        begin
            cur_bytes[0] = LEAD2_MARK | {3'b000, s_tdata[10:6]};
            cur_bytes[1] = CONT_MARK  | {2'b00, s_tdata[5:0]};
            cur_cnt      = CNT_W'(2);
        end
        else if (is_hi)
        begin
            cur_cnt = '0;
        end
        else
        begin
            cur_bytes[0] = LEAD3_MARK | {4'h0, s_tdata[15:12]};
            cur_bytes[1] = CONT_MARK  | {2'b00, s_tdata[11:6]};
            cur_bytes[2] = CONT_MARK  | {2'b00, s_tdata[5:0]};
            cur_cnt      = CNT_W'(3);
        end
    end

    // Full byte sequence caused by the unit, flushed surrogate first
    always_comb
    begin
        enc_bytes = '0;
        enc_cnt   = cur_cnt;
        if (pair)
        begin
            enc_bytes[0] = LEAD4_MARK | {5'b00000, plane_bits[10:8]};
            enc_bytes[1] = CONT_MARK  | {2'b00, plane_bits[7:2]};
            enc_bytes[2] = CONT_MARK  | {2'b00, plane_bits[1:0], s_tdata[9:6]};
            enc_bytes[3] = CONT_MARK  | {2'b00, s_tdata[5:0]};
            enc_cnt      = CNT_W'(4);
        end
        else if (flush)
        begin
            enc_bytes[0] = LEAD3_MARK | {4'h0, SURR_NIBBLE};
            enc_bytes[1] = CONT_MARK  | {2'b00, held_unit[11:6]};
            enc_bytes[2] = CONT_MARK  | {2'b00, held_unit[5:0]};
            enc_bytes[3] = cur_bytes[0];
            enc_bytes[4] = cur_bytes[1];
            enc_bytes[5] = cur_bytes[2];
            enc_cnt      = CNT_W'(cur_cnt + CNT_W'(3));
        end
        else
        begin
            enc_bytes[0] = cur_bytes[0];
            enc_bytes[1] = cur_bytes[1];
            enc_bytes[2] = cur_bytes[2];
        end
    end

    always_comb
    begin
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        end_next        = end_reg;
        m_tvalid_next   = m_tvalid_reg;

        if (out_load)
        begin
            // Advance the buffer by one byte
            buf_next      = {{BYTE_W{1'b0}}, buf_reg[MAX_BYTES-1:1]};
            cnt_next      = cnt_reg - CNT_W'(1);
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (s_xfer)
        begin
            buf_next = enc_bytes;
            cnt_next = enc_cnt;
            end_next = (s_tdata == '0);
            if (!pair && is_hi)
            begin
                held_next       = s_tdata[9:0];
                held_valid_next = 1'b1;
            end
            else
            begin
                held_next       = '0;
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            end_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            cnt_reg        <= cnt_next;
            end_reg        <= end_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (out_load)
        begin
            m_tdata_reg <= buf_reg[0];
            m_tlast_reg <= (cnt_reg == CNT_W'(1));
            m_tuser_reg <= (cnt_reg == CNT_W'(1)) && end_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `U16U8_ASSERT_NOW(a_ready_drained, s_tready, cnt_reg <= CNT_W'(1), "input ready with bytes still buffered")
    `U16U8_ASSERT_NOW(a_end_is_last, m_tvalid && m_tuser, m_tlast, "string end not on last byte of unit")
    `U16U8_ASSERT_NEXT(a_pair_four, s_xfer && held_valid_reg && is_lo, (cnt_reg == CNT_W'(4)) && !held_valid_reg, "surrogate pair did not give four bytes")
    `U16U8_ASSERT_NEXT(a_zero_clears, s_xfer && (s_tdata == '0), !held_valid_reg && end_reg, "zero unit left a surrogate held")

endmodule

// File: bench/utf8_byte_checker.sv
// Checker for the UTF-16 to UTF-8 encoder: predicts the byte stream and compares it.
module utf8_byte_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [u16u8_pkg::UNIT_W-1:0] s_tdata,   // [15:0] code_unit
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [u16u8_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    input  logic                         m_tlast,   // run_last
    input  logic                         m_tuser,   // [0] string_end
    output int                           fail_count,
    output int                           bytes_owed
);
    import u16u8_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              str_end;
    } utf8_byte_t;

    utf8_byte_t expected_utf8 [$];

    // Predictor state: low ten bits of a held high surrogate
    logic [9:0] held_hi10 = '0;
    logic       held_on   = 1'b0;
    int         byte_index = 0;

    initial
    begin
        fail_count = 0;
        bytes_owed = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] byte %0d: %s got 0x%0h expected 0x%0h", $realtime, byte_index, what,
                 got, want);
        fail_count++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic str_end);
        utf8_byte_t b;
        b.data    = data;
        b.last    = 1'b0;
        b.str_end = str_end;
        expected_utf8.push_back(b);
    endtask

    task automatic push_three(input logic [UNIT_W-1:0] u);
        push_byte(LEAD3_MARK | {4'b0, u[15:12]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, u[11:6]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, u[5:0]}, 1'b0);
    endtask

    task automatic encode_unit(input logic [UNIT_W-1:0] u);
        int         start;
        logic [20:0] cp;
        start = expected_utf8.size();
        if (held_on && u[15:10] == SURR_LO_TAG)
        begin
            cp = 21'h10000 + {1'b0, held_hi10, u[9:0]};
            push_byte(LEAD4_MARK | {5'b0, cp[20:18]}, 1'b0);
            push_byte(CONT_MARK | {2'b0, cp[17:12]}, 1'b0);
            push_byte(CONT_MARK | {2'b0, cp[11:6]}, 1'b0);
            push_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b0);
            held_on   = 1'b0;
            held_hi10 = '0;
        end
        else
        begin
            // Flush a held surrogate that found no partner
            if (held_on)
            begin
                push_three({SURR_HI_TAG, held_hi10});
                held_on   = 1'b0;
                held_hi10 = '0;
            end
            if (u == '0)
                push_byte('0, 1'b1);
            else if (u[15:7] == '0)
                push_byte(u[7:0], 1'b0);
            else if (u[15:11] == '0)
            begin
                push_byte(LEAD2_MARK | {3'b0, u[10:6]}, 1'b0);
                push_byte(CONT_MARK | {2'b0, u[5:0]}, 1'b0);
            end
            else if (u[15:10] == SURR_HI_TAG)
            begin
                held_hi10 = u[9:0];
                held_on   = 1'b1;
            end
            else
                push_three(u);
        end
        if (expected_utf8.size() > start)
            expected_utf8[expected_utf8.size()-1].last = 1'b1;
    endtask

    always @(posedge clk)
    begin
        utf8_byte_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                encode_unit(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_utf8.size() == 0)
                    report("unexpected byte", 32'(m_tdata), 32'd0);
                else
                begin
                    want = expected_utf8.pop_front();
                    if (m_tdata !== want.data)
                        report("out_byte", 32'(m_tdata), 32'(want.data));
                    if (m_tlast !== want.last)
                        report("run_last", 32'(m_tlast), 32'(want.last));
                    if (m_tuser !== want.str_end)
                        report("string_end", 32'(m_tuser), 32'(want.str_end));
                end
                byte_index++;
            end
        end
        bytes_owed <= expected_utf8.size();
    end

endmodule

// File: bench/tb_utf16be_to_utf8_encoder.sv
// Testbench top for the UTF-16 to UTF-8 encoder: stimulus, flow control and verdict.
module tb_utf16be_to_utf8_encoder;
    import u16u8_pkg::*;

    localparam int UNIT_COUNT = 360;
    localparam int IDLE_LIMIT = 3000;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [UNIT_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    int   fail_count;
    int   bytes_owed;
    int   units_sent = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;

    utf16be_to_utf8_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    utf8_byte_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .bytes_owed (bytes_owed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Sink side: random stalls, with stretches of steady ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
        if ($urandom_range(0, 63) == 0)
            rx_steady <= !rx_steady;
    end

    // Abort when the stream stops moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** utf16be_to_utf8_encoder: FAILED **");
            $finish;
        end
    end

    task automatic send_unit(input logic [UNIT_W-1:0] u);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        do @(posedge clk); while (!s_tready);
        units_sent++;
    endtask

    task automatic send_random_units();
        int r;
        while (units_sent < UNIT_COUNT)
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
                send_unit(UNIT_W'($urandom_range(1, 16'h007F)));
            else if (r < 32)
                send_unit(UNIT_W'($urandom_range(16'h0080, 16'h07FF)));
            else if (r < 40)
                send_unit(UNIT_W'($urandom_range(16'h0800, 16'hD7FF)));
            else if (r < 46)
                send_unit(UNIT_W'($urandom_range(16'hE000, 16'hFFFF)));
            else if (r < 72)
            begin
                // well-formed surrogate pair
                send_unit(UNIT_W'($urandom_range(16'hD800, 16'hDBFF)));
                send_unit(UNIT_W'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            else if (r < 80)
                send_unit(UNIT_W'($urandom_range(16'hD800, 16'hDBFF)));
            else if (r < 86)
                send_unit(UNIT_W'($urandom_range(16'hDC00, 16'hDFFF)));
            else if (r < 92)
                send_unit('0);
            else
                send_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    initial
    begin
        logic [UNIT_W-1:0] directed_units [$];
        directed_units = '{
            16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
            16'hD800, 16'hDC00,            // lowest pair
            16'hDBFF, 16'hDFFF,            // highest pair, plane 16
            16'hDC00, 16'hDFFF,            // lone low surrogates
            16'hD801, 16'hDA55,            // high followed by high
            16'h0041,                      // held unit flushed by ASCII
            16'hD9AB, 16'h0000,            // held unit flushed by zero
            16'hDBC0, 16'h0123,            // held unit flushed by two-byte unit
            16'hD7FF, 16'hE000, 16'h0000, 16'h5AA5
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_units[i])
            send_unit(directed_units[i]);
        send_random_units();
        s_tvalid <= 1'b0;
        // Let the count of owed bytes catch up with the last transfer
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (fail_count == 0 && bytes_owed == 0)
            $display("** utf16be_to_utf8_encoder: PASSED **");
        else
            $display("** utf16be_to_utf8_encoder: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/u16u8_pkg.sv
src/utf16be_to_utf8_encoder.sv
bench/utf8_byte_checker.sv
bench/tb_utf16be_to_utf8_encoder.sv
